// File: design/pta_pkg.sv
// pta_pkg: shared types and constants for the primitive triangle assembler
// no dependencies; used by all design modules
package pta_pkg;

  // command codes carried on the input tuser
  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_VERTEX = 2'd1;
  localparam logic [1:0] CMD_NORMAL = 2'd2;
  localparam logic [1:0] CMD_END    = 2'd3;

  // primitive modes
  localparam logic [3:0] MODE_FAN   = 4'd6;
  localparam logic [3:0] MODE_QUADS = 4'd7;
  localparam logic [3:0] MODE_STRIP = 4'd8;

  localparam logic [31:0] ONE_F32 = 32'h3F80_0000;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 200;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // corner steps within a job (quads run all six, single triangles stop at 2)
  localparam logic [2:0] STEP_TRI_LAST  = 3'd2;
  localparam logic [2:0] STEP_QUAD_LAST = 3'd5;

  typedef struct packed {
    logic [31:0] z;
    logic [31:0] y;
    logic [31:0] x;
  } vec3_t;

  // one or two triangles: (a,b,c) and, for quads, (a,d,c)
  typedef struct packed {
    vec3_t va;
    vec3_t vb;
    vec3_t vc;
    vec3_t vd;
    vec3_t nrm;
    logic  quad;
  } tri_job_t;

  typedef struct packed {
    logic push;
  } q_wr_ctl_t;

  typedef struct packed {
    logic valid;
  } q_rd_ctl_t;

endpackage

// File: design/pta_front.sv
// pta_front: command decode, primitive state and vertex window
// depends on pta_pkg; pushes triangle jobs into pta_queue
module pta_front
  import pta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [1:0]           s_tuser,
  output logic                 push,
  input  logic                 full,
  output tri_job_t             job
);

  logic [3:0]  active_mode;
  logic        in_primitive;
  logic [1:0]  vertex_count;
  vec3_t       current_normal;
  vec3_t       slot0, slot1, slot2;
  vec3_t       slot0_nrm;

  logic        acc;
  logic [1:0]  func;
  logic [3:0]  prim_mode;
  vec3_t       vin;
  logic        is_quads, is_strip, is_fan, is_vtx;

  assign func      = s_tuser;
  assign prim_mode = s_tdata[3:0];
  assign vin.x     = s_tdata[35:4];
  assign vin.y     = s_tdata[67:36];
  assign vin.z     = s_tdata[99:68];

  assign s_tready = !full;
  assign acc      = s_tvalid && s_tready;

  assign is_quads = (active_mode == MODE_QUADS);
  assign is_strip = (active_mode == MODE_STRIP);
  assign is_fan   = (active_mode == MODE_FAN);
  assign is_vtx   = acc && (func == CMD_VERTEX) && in_primitive;

  assign push = is_vtx && ((is_quads && vertex_count == 2'd3) ||
                           ((is_strip || is_fan) && vertex_count == 2'd2));

  always_comb begin
    job.va   = slot0;
    job.vb   = slot1;
    job.vc   = is_quads ? slot2 : vin;
    job.vd   = vin;
    job.nrm  = is_quads ? slot0_nrm : current_normal;
    job.quad = is_quads;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_mode      <= '0;
      in_primitive     <= 1'b0;
      vertex_count     <= '0;
      current_normal.x <= '0;
      current_normal.y <= '0;
      current_normal.z <= ONE_F32;
    end else if (acc) begin
      case (func)
        CMD_BEGIN: begin
          active_mode  <= prim_mode;
          in_primitive <= 1'b1;
          vertex_count <= '0;
        end
        CMD_NORMAL: begin
          current_normal <= vin;
        end
        CMD_END: begin
          in_primitive <= 1'b0;
          vertex_count <= '0;
        end
        default: begin
          if (in_primitive) begin
            if (is_quads) begin
              vertex_count <= vertex_count + 2'd1;
            end else if ((is_strip || is_fan) && vertex_count != 2'd2) begin
              vertex_count <= vertex_count + 2'd1;
            end
          end
        end
      endcase
    end
  end

  // window payload, no reset needed
  always_ff @(posedge clk) begin
    if (is_vtx) begin
      if (is_quads) begin
        case (vertex_count)
          2'd0: begin
            slot0     <= vin;
            slot0_nrm <= current_normal;
          end
          2'd1: slot1 <= vin;
          2'd2: slot2 <= vin;
          default: ;
        endcase
      end else if (is_strip || is_fan) begin
        case (vertex_count)
          2'd0: slot0 <= vin;
          2'd1: slot1 <= vin;
          default: begin
            if (is_strip) begin
              slot0 <= slot1;
            end
            slot1 <= vin;
          end
        endcase
      end
    end
  end

endmodule

// File: design/pta_queue.sv
// pta_queue: short job queue between front and back
// depends on pta_pkg
module pta_queue
  import pta_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_wr_ctl_t wr_in,
  output logic      full,
  input  tri_job_t  wr_job,
  input  logic      pop,
  output logic      valid,
  output tri_job_t  rd_job
);

  tri_job_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign valid   = (count != '0);
  assign do_push = wr_in.push && !full;
  assign do_pop  = pop && valid;
  assign rd_job  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/pta_back.sv
// pta_back: walks a job one corner per unstalled cycle into the output register
// depends on pta_pkg; reads the head of pta_queue
module pta_back
  import pta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  q_rd_ctl_t            head_in,
  output logic                 pop,
  input  tri_job_t             head,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,
  output logic                 m_tlast
);

  logic [2:0] step;
  logic       adv, last_step;
  logic [1:0] corner_index;
  vec3_t      corner;

  logic [1:0] out_index;
  vec3_t      out_corner;
  vec3_t      out_nrm;

  assign adv       = !m_tvalid || m_tready;
  assign last_step = head.quad ? (step == STEP_QUAD_LAST) : (step == STEP_TRI_LAST);
  assign pop       = adv && head_in.valid && last_step;

  always_comb begin
    corner_index = (step > 3'd2) ? 2'(step - 3'd3) : step[1:0];
    case (step)
      3'd0, 3'd3: corner = head.va;
      3'd1:       corner = head.vb;
      3'd4:       corner = head.vd;
      default:    corner = head.vc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
    end else if (adv) begin
      m_tvalid <= head_in.valid;
      if (head_in.valid) begin
        m_tlast <= last_step;
        step    <= last_step ? 3'd0 : step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && head_in.valid) begin
      out_index  <= corner_index;
      out_corner <= corner;
      out_nrm    <= head.nrm;
    end
  end

  assign m_tdata = {6'd0, out_nrm.z, out_nrm.y, out_nrm.x,
                    out_corner.z, out_corner.y, out_corner.x, out_index};

endmodule

// File: design/primitive_triangle_assembler.sv
// primitive_triangle_assembler: top level, front decode, job queue and corner output
// depends on pta_pkg, pta_front, pta_queue, pta_back
//
// Accepts begin, vertex, set-normal and end commands and emits triangles as
// corner transactions (corners 0, 1, 2; tlast on the final corner caused by
// one input). Begin, end, set-normal and vertices that complete nothing are
// accepted back to back while the job queue has room. A fan or strip vertex
// that completes a triangle yields three corners and a fourth quad vertex
// six; the single corner output register sends one corner per cycle while
// m_tready holds, so sustained fan and strip input is paced by the corners.
// A two-entry job queue lets the input keep running while corners drain;
// with the queue full every input command waits.
module primitive_triangle_assembler
  import pta_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // s_tdata: prim_mode[3:0], x_bits[35:4], y_bits[67:36], z_bits[99:68], zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // s_tuser: func[1:0]
  input  logic [1:0]           s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // m_tdata: corner_index[1:0], corner_x, corner_y, corner_z,
  //          facet_nx, facet_ny, facet_nz (32 bits each from bit 2), zero pad
  output logic [M_TDATA_W-1:0] m_tdata,
  // m_tlast: last_of_run
  output logic                 m_tlast
);

  q_wr_ctl_t wr_ctl;
  q_rd_ctl_t rd_ctl;
  tri_job_t  push_job, head_job;
  logic      push, full, q_valid, pop;

  assign wr_ctl.push  = push;
  assign rd_ctl.valid = q_valid;

  pta_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .full     (full),
    .job      (push_job)
  );

  pta_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_in  (wr_ctl),
    .full   (full),
    .wr_job (push_job),
    .pop    (pop),
    .valid  (q_valid),
    .rd_job (head_job)
  );

  pta_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head_in  (rd_ctl),
    .pop      (pop),
    .head     (head_job),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// File: design/pta_checker.sv
// pta_checker: port-level checks for primitive_triangle_assembler
// depends on pta_pkg; attached to the top level by the bind below
module pta_checker
  import pta_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast
);

  // nothing pending on the output right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // stalled corner holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled corner changed");

  a_corner_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[1:0] != 2'd3)
    else $error("corner index out of range");

  // a run always ends on a triangle's third corner
  a_last_corner: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[1:0] == 2'd2)
    else $error("tlast on a corner other than the third");

endmodule

bind primitive_triangle_assembler pta_checker u_pta_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: tb/tb.sv
// tb: self-checking testbench for primitive_triangle_assembler
// depends on pta_pkg and the design; directed command table, then random primitive sequences
`timescale 1ns / 100ps

module tb;
  import pta_pkg::*;

  localparam int RAND_ITEMS = 253;
  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 20;
  localparam int DIR_N = 27;

  typedef struct packed {
    vec3_t pos;
    vec3_t nrm;
  } vtx_t;

  typedef struct packed {
    logic [1:0] idx;
    vec3_t      pos;
    vec3_t      nrm;
    logic       last;
  } corner_t;

  // one directed command and the number of corners it must cause
  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  mode;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [2:0]  corners;
  } cmd_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic [1:0]           s_tuser = CMD_END;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;

  // predictor state
  logic [3:0]  prim_mode_q;
  logic        in_prim;
  vec3_t       cur_nrm;
  vtx_t        window [4];
  logic [1:0]  vtx_cnt;

  corner_t     corner_q [$];
  int          mismatches = 0;
  int          accepted = 0;
  int          cycle_cnt = 0;
  bit          calm = 1'b0;

  cmd_row_t dir_tbl [DIR_N] = '{
    // vertex right after reset is outside any primitive
    '{CMD_VERTEX, 4'd0,  32'h1, 32'h2, 32'h3, 3'd0},
    '{CMD_BEGIN,  MODE_QUADS, 32'h0, 32'h0, 32'h0, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 3'd0},
    '{CMD_VERTEX, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h5555_5555, 32'hAAAA_AAAA, 32'h3F80_0000, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'hAAAA_AAAA, 32'h5555_5555, 32'h8000_0000, 3'd6},
    '{CMD_NORMAL, 4'd0,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, 3'd0},
    // begin inside a primitive drops the held quad vertex
    '{CMD_BEGIN,  MODE_FAN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h10, 32'h11, 32'h12, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h20, 32'h21, 32'h22, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h30, 32'h31, 32'h32, 3'd3},
    '{CMD_NORMAL, 4'd0,  32'h0, 32'h0, 32'h0, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h40, 32'h41, 32'h42, 3'd3},
    '{CMD_BEGIN,  MODE_STRIP, 32'h0, 32'h0, 32'h0, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h50, 32'h51, 32'h52, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h60, 32'h61, 32'h62, 3'd0},
    '{CMD_NORMAL, 4'd0,  32'h0, 32'h0, ONE_F32, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h70, 32'h71, 32'h72, 3'd3},
    '{CMD_VERTEX, 4'd0,  32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 3'd3},
    '{CMD_END,    4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd0},
    '{CMD_BEGIN,  MODE_QUADS, 32'h0, 32'h0, 32'h0, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h80, 32'h81, 32'h82, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'h90, 32'h91, 32'h92, 3'd0},
    // end with two quad vertices held: nothing comes out
    '{CMD_END,    4'd0,  32'h0, 32'h0, 32'h0, 3'd0},
    '{CMD_BEGIN,  4'd15, 32'h0, 32'h0, 32'h0, 3'd0},
    '{CMD_VERTEX, 4'd0,  32'hA0, 32'hA1, 32'hA2, 3'd0}
  };

  primitive_triangle_assembler DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic emit_triangle(input vtx_t a, input vtx_t b, input vtx_t c,
                               input vec3_t n, input bit last);
    corner_q.push_back('{2'd0, a.pos, n, 1'b0});
    corner_q.push_back('{2'd1, b.pos, n, 1'b0});
    corner_q.push_back('{2'd2, c.pos, n, last});
  endtask

  // works out the corners one accepted command causes; returns how many
  task automatic assemble_corners(input logic [1:0] func, input logic [3:0] mode,
                                  input vec3_t p, output int n);
    vtx_t nv;
    n = 0;
    nv.pos = p;
    nv.nrm = cur_nrm;
    case (func)
      CMD_BEGIN: begin
        prim_mode_q = mode;
        in_prim = 1'b1;
        vtx_cnt = 2'd0;
      end
      CMD_NORMAL: begin
        cur_nrm = p;
      end
      CMD_END: begin
        in_prim = 1'b0;
        vtx_cnt = 2'd0;
      end
      default: begin
        if (in_prim && prim_mode_q == MODE_QUADS) begin
          window[vtx_cnt] = nv;
          if (vtx_cnt == 2'd3) begin
            emit_triangle(window[0], window[1], window[2], window[0].nrm, 1'b0);
            emit_triangle(window[0], window[3], window[2], window[0].nrm, 1'b1);
            n = 6;
          end
          vtx_cnt = vtx_cnt + 2'd1;
        end else if (in_prim && (prim_mode_q == MODE_STRIP || prim_mode_q == MODE_FAN)) begin
          if (vtx_cnt < 2'd2) begin
            window[vtx_cnt] = nv;
            vtx_cnt = vtx_cnt + 2'd1;
          end else begin
            emit_triangle(window[0], window[1], nv, nv.nrm, 1'b1);
            n = 3;
            // strip slides the window, fan keeps its anchor
            if (prim_mode_q == MODE_STRIP)
              window[0] = window[1];
            window[1] = nv;
          end
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch: %s", $realtime, what);
  endtask

  task automatic check_corner();
    corner_t want;
    corner_t got;
    got.idx = m_tdata[1:0];
    got.pos.x = m_tdata[33:2];
    got.pos.y = m_tdata[65:34];
    got.pos.z = m_tdata[97:66];
    got.nrm.x = m_tdata[129:98];
    got.nrm.y = m_tdata[161:130];
    got.nrm.z = m_tdata[193:162];
    got.last = m_tlast;
    if (corner_q.size() == 0) begin
      note_mismatch($sformatf("unexpected corner idx=%0d pos=%h nrm=%h last=%b",
                              got.idx, got.pos, got.nrm, got.last));
    end else begin
      want = corner_q.pop_front();
      if (want.idx !== got.idx || want.pos.x !== got.pos.x || want.pos.y !== got.pos.y ||
          want.pos.z !== got.pos.z || want.nrm.x !== got.nrm.x ||
          want.nrm.y !== got.nrm.y || want.nrm.z !== got.nrm.z || want.last !== got.last)
        note_mismatch($sformatf(
          "corner exp idx=%0d pos=%h nrm=%h last=%b, got idx=%0d pos=%h nrm=%h last=%b",
          want.idx, want.pos, want.nrm, want.last, got.idx, got.pos, got.nrm, got.last));
    end
  endtask

  // input and output transactions are taken from the values present before the edge
  always @(posedge clk) begin
    int n;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        assemble_corners(s_tuser, s_tdata[3:0],
                         '{z: s_tdata[99:68], y: s_tdata[67:36], x: s_tdata[35:4]}, n);
        if (accepted < DIR_N && n != int'(dir_tbl[accepted].corners))
          note_mismatch($sformatf("table row %0d: expected %0d corners, predicted %0d",
                                  accepted, dir_tbl[accepted].corners, n));
        accepted++;
      end
      if (m_tvalid && m_tready)
        check_corner();
    end
  end

  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 18);
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // call right after a rising edge; returns at the edge the transaction is accepted
  task automatic send_cmd(input logic [1:0] func, input logic [3:0] mode,
                          input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
    while (!calm && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {4'b0, z, y, x, mode};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(99);
    if (r < 8)
      return 32'h0;
    else if (r < 16)
      return 32'hFFFF_FFFF;
    else
      return $urandom;
  endfunction

  function automatic logic [3:0] pick_mode();
    int r;
    r = $urandom_range(99);
    if (r < 30)
      return MODE_FAN;
    else if (r < 60)
      return MODE_QUADS;
    else if (r < 90)
      return MODE_STRIP;
    else
      return 4'($urandom_range(15));
  endfunction

  initial begin
    int nverts;
    prim_mode_q = 4'd0;
    in_prim = 1'b0;
    cur_nrm = '{z: ONE_F32, y: 32'h0, x: 32'h0};
    vtx_cnt = 2'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++)
      send_cmd(dir_tbl[i].func, dir_tbl[i].mode, dir_tbl[i].x, dir_tbl[i].y, dir_tbl[i].z);

    while (accepted < DIR_N + RAND_ITEMS) begin
      calm = (accepted >= 120 && accepted < 180);
      if ($urandom_range(99) < 85) begin
        // well-formed primitive with random content
        send_cmd(CMD_BEGIN, pick_mode(), rand_word(), rand_word(), rand_word());
        nverts = ($urandom_range(3) == 0) ? 4 * $urandom_range(1, 3) : $urandom_range(0, 9);
        for (int v = 0; v < nverts; v++) begin
          if ($urandom_range(99) < 15)
            send_cmd(CMD_NORMAL, 4'($urandom_range(15)), rand_word(), rand_word(),
                     rand_word());
          send_cmd(CMD_VERTEX, 4'($urandom_range(15)), rand_word(), rand_word(),
                   rand_word());
        end
        if ($urandom_range(99) < 85)
          send_cmd(CMD_END, 4'($urandom_range(15)), rand_word(), rand_word(), rand_word());
      end else begin
        send_cmd(2'($urandom_range(3)), 4'($urandom_range(15)), rand_word(), rand_word(),
                 rand_word());
      end
    end
    calm = 1'b0;
    s_tvalid <= 1'b0;

    while (corner_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && corner_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
